[rtl/brush_falloff_height_blend_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the brush falloff height blend.
// The including module must have aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef BRUSH_FALLOFF_HEIGHT_BLEND_ASSERT_SVH
`define BRUSH_FALLOFF_HEIGHT_BLEND_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFHB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFHB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bfhb_pkg.sv]
// ----------------------------------------------------------------------------
// bfhb_pkg
// Shared types, codes and fixed widths of the brush falloff height blend.
// ----------------------------------------------------------------------------
package bfhb_pkg;

    // Default parameter values.
    localparam int HEIGHT_WIDTH_DEF = 32;
    localparam int OFFSET_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int KIND_W     = 3;
    localparam int STRENGTH_W = 16;
    localparam int INFL_W     = 17;
    localparam int RADIUS_W   = 16;
    localparam int TARGET_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Square root of the cell distance: radicand is the squared distance, Q34.16.
    localparam int RAD_W  = 2 * (RADIUS_W + 1) + 16;
    localparam int ROOT_W = RAD_W / 2;

    // Influence of 1.0 in Q1.16.
    localparam logic [INFL_W-1:0] INFL_ONE = INFL_W'(65536);

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_RAISE   = 3'd1,
        KIND_SMOOTH  = 3'd2,
        KIND_RESET   = 3'd3,
        KIND_FLATTEN = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_RADIUS    = 2'd0,
        CFG_BAND_WIDTH     = 2'd1,
        CFG_FLATTEN_TARGET = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [RADIUS_W-1:0]        full_radius;
        logic [RADIUS_W-1:0]        band_width;
        logic signed [TARGET_W-1:0] flatten_target;
    } cfg_t;

    // Distance class of a cell relative to the brush.
    typedef struct packed {
        logic in_core;
        logic in_band;
    } dist_cls_t;

endpackage

[rtl/brush_falloff_height_blend.sv]
// ----------------------------------------------------------------------------
// brush_falloff_height_blend
// Per grid cell brush influence and height update for terrain editing.
//
//   Channel | Ports                          | Contents
//   --------+--------------------------------+------------------------------
//   input   | s_tvalid s_tready s_tdata/user | one cell: offsets, heights, strength, kind
//   result  | m_tvalid m_tready m_tdata      | new height, falloff, flag
//   config  | cfg_we cfg_index cfg_data      | radius, band, flatten target
//
// One cell enters per cycle while no untaken result stalls the pipeline.
// The square root has 25 stages and the divider 17.
// Reset is synchronous and empties the pipeline; config returns to defaults.
// A stall on the result side freezes every stage together, so s_tready drops
// in the same cycle and no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module brush_falloff_height_blend import bfhb_pkg::*; #(
    parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    localparam int S_FIELDS_W  = 2 * OFFSET_WIDTH + 6 * HEIGHT_WIDTH + STRENGTH_W,
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((HEIGHT_WIDTH + INFL_W + 1 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // offset_x, offset_y, base_height, strength, initial_height,
    // sample_east, sample_west, sample_south, sample_north
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_height, falloff, saturated
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "brush_falloff_height_blend_assert.svh"

    localparam int HW     = HEIGHT_WIDTH;
    localparam int OW     = OFFSET_WIDTH;
    localparam int P_DY   = OW;
    localparam int P_BASE = 2 * OW;
    localparam int P_STR  = P_BASE + HW;
    localparam int P_INIT = P_STR + STRENGTH_W;
    localparam int P_EAST = P_INIT + HW;
    localparam int P_WEST = P_EAST + HW;
    localparam int P_SOUT = P_WEST + HW;
    localparam int P_NORT = P_SOUT + HW;
    localparam int SIDE_W = KIND_W + STRENGTH_W + 3 * HW;

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_radius    <= RADIUS_W'(256);
            cfg_reg.band_width     <= RADIUS_W'(256);
            cfg_reg.flatten_target <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_FULL_RADIUS:    cfg_reg.full_radius    <= cfg_data[RADIUS_W-1:0];
                CFG_BAND_WIDTH:     cfg_reg.band_width     <= cfg_data[RADIUS_W-1:0];
                CFG_FLATTEN_TARGET: cfg_reg.flatten_target <= cfg_data[TARGET_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless the output register holds an untaken result.
    // No transfer is taken while reset holds the pipeline empty.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && aresetn;

    // Neighbour mean is formed on entry so only one height travels for it.
    logic signed [OW-1:0]     dx, dy;
    logic signed [HW+1:0]     sum4;
    logic signed [HW-1:0]     mean_in;
    logic [SIDE_W-1:0]        side_in, side_out;

    always_comb begin
        dx      = $signed(s_tdata[OW-1:0]);
        dy      = $signed(s_tdata[P_DY +: OW]);
        sum4    = (HW+2)'($signed(s_tdata[P_EAST +: HW]))
                + (HW+2)'($signed(s_tdata[P_WEST +: HW]))
                + (HW+2)'($signed(s_tdata[P_SOUT +: HW]))
                + (HW+2)'($signed(s_tdata[P_NORT +: HW]));
        mean_in = sum4[HW+1:2];
        side_in = {s_tuser, s_tdata[P_STR +: STRENGTH_W], s_tdata[P_BASE +: HW],
                   s_tdata[P_INIT +: HW], mean_in};
    end

    logic              fo_valid;
    logic [INFL_W-1:0] fo_infl;

    bfhb_falloff #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .SIDE_W       (SIDE_W)
    ) u_falloff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .dx        (dx),
        .dy        (dy),
        .in_side   (side_in),
        .out_valid (fo_valid),
        .infl      (fo_infl),
        .out_side  (side_out)
    );

    logic signed [HW-1:0] new_height;
    logic [INFL_W-1:0]    falloff;
    logic                 saturated;

    bfhb_blend #(
        .HEIGHT_WIDTH (HEIGHT_WIDTH)
    ) u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .target     (cfg_reg.flatten_target),
        .in_valid   (fo_valid),
        .infl       (fo_infl),
        .kind       (side_out[SIDE_W-1 -: KIND_W]),
        .force_q    ($signed(side_out[3*HW +: STRENGTH_W])),
        .base       ($signed(side_out[2*HW +: HW])),
        .init       ($signed(side_out[HW +: HW])),
        .mean       ($signed(side_out[HW-1:0])),
        .out_valid  (m_tvalid),
        .new_height (new_height),
        .falloff    (falloff),
        .saturated  (saturated)
    );

    // Pack the result fields from the lowest bit up.
    always_comb begin
        m_tdata                   = '0;
        m_tdata[HW-1:0]           = new_height;
        m_tdata[HW +: INFL_W]     = falloff;
        m_tdata[HW + INFL_W]      = saturated;
    end

    `BFHB_ASSERT_IMP(a_falloff_max, m_tvalid, falloff <= INFL_ONE, "falloff above 1.0")
    `BFHB_ASSERT_IMP(a_sat_at_limit, m_tvalid && saturated,
        (new_height == $signed({1'b0, {(HW-1){1'b1}}})) ||
        (new_height == $signed({1'b1, {(HW-1){1'b0}}})), "saturated height off limit")
    `BFHB_ASSERT_NXT(a_cfg_hard, cfg_we && (cfg_index == CFG_FULL_RADIUS),
        cfg_reg.full_radius == $past(cfg_data[RADIUS_W-1:0]), "hard radius write lost")

endmodule

[rtl/bfhb_falloff.sv]
// ----------------------------------------------------------------------------
// bfhb_falloff
// Distance classification, pipelined square root and pipelined division that
// turn a cell offset into a Q1.16 influence. A side vector travels alongside.
// ----------------------------------------------------------------------------
module bfhb_falloff import bfhb_pkg::*; #(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    parameter int SIDE_W       = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  cfg_t                           cfg,
    input  logic                           in_valid,
    input  logic signed [OFFSET_WIDTH-1:0] dx,
    input  logic signed [OFFSET_WIDTH-1:0] dy,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic [INFL_W-1:0]              infl,
    output logic [SIDE_W-1:0]              out_side
);

    localparam int SQ_W   = 2 * OFFSET_WIDTH;
    localparam int CMP_W  = (SQ_W > 2 * (RADIUS_W + 1)) ? SQ_W : 2 * (RADIUS_W + 1);
    localparam int OSQ_W  = 2 * (RADIUS_W + 1);
    localparam int REM_W  = ROOT_W + 2;
    localparam int DIV_N  = INFL_W;

    // Stage 1: squares of the offsets and of the radii.
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [2*RADIUS_W-1:0] hard_sq_reg;
    logic [OSQ_W-1:0]      outer_sq_reg;
    logic                  band_nz_reg;
    logic                  v1_reg;
    logic [SIDE_W-1:0]     side1_reg;

    logic signed [SQ_W-1:0] px, py;
    logic [RADIUS_W:0]      outer;

    always_comb begin
        px    = dx * dx;
        py    = dy * dy;
        outer = (RADIUS_W + 1)'(cfg.full_radius) + (RADIUS_W + 1)'(cfg.band_width);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            sqx_reg      <= px;
            sqy_reg      <= py;
            hard_sq_reg  <= (2 * RADIUS_W)'(cfg.full_radius)
                          * (2 * RADIUS_W)'(cfg.full_radius);
            outer_sq_reg <= OSQ_W'(outer) * OSQ_W'(outer);
            band_nz_reg  <= (cfg.band_width != '0);
            side1_reg    <= in_side;
        end
    end

    // Stage 2 and the square root pipeline; index 0 holds the classified radicand.
    logic [RAD_W-1:0]  sq_rad_reg  [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W+1];
    dist_cls_t         sq_cls_reg  [ROOT_W+1];
    logic              sq_v_reg    [ROOT_W+1];
    logic [SIDE_W-1:0] sq_side_reg [ROOT_W+1];

    logic [CMP_W-1:0]  d2;
    dist_cls_t         cls_next;
    logic [REM_W-1:0]  sq_rem_next  [ROOT_W];
    logic [ROOT_W-1:0] sq_root_next [ROOT_W];

    always_comb begin
        d2               = CMP_W'(sqx_reg) + CMP_W'(sqy_reg);
        cls_next.in_core = (d2 <= CMP_W'(hard_sq_reg));
        cls_next.in_band = band_nz_reg && (d2 <= CMP_W'(outer_sq_reg));
    end

    // One result bit of the square root per stage.
    always_comb begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < ROOT_W; k++) begin
            rem_sh = {sq_rem_reg[k][REM_W-3:0], sq_rad_reg[k][RAD_W-1 -: 2]};
            trial  = {sq_root_reg[k], 2'b01};
            if (rem_sh >= trial) begin
                sq_rem_next[k]  = rem_sh - trial;
                sq_root_next[k] = {sq_root_reg[k][ROOT_W-2:0], 1'b1};
            end else begin
                sq_rem_next[k]  = rem_sh;
                sq_root_next[k] = {sq_root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= ROOT_W; k++) begin
                sq_v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            sq_v_reg[0] <= v1_reg;
            for (int k = 0; k < ROOT_W; k++) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end
        if (en) begin
            sq_rad_reg[0]  <= {d2[OSQ_W-1:0], 16'b0};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_cls_reg[0]  <= cls_next;
            sq_side_reg[0] <= side1_reg;
            for (int k = 0; k < ROOT_W; k++) begin
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][RAD_W-3:0], 2'b00};
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_cls_reg[k+1]  <= sq_cls_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // Division of the band position by the band width, one quotient bit per stage.
    logic [RADIUS_W-1:0] dv_rem_reg  [DIV_N+1];
    logic [INFL_W-1:0]   dv_dq_reg   [DIV_N+1];
    dist_cls_t           dv_cls_reg  [DIV_N+1];
    logic                dv_v_reg    [DIV_N+1];
    logic [SIDE_W-1:0]   dv_side_reg [DIV_N+1];

    logic [ROOT_W-1:0]   num;
    logic [RADIUS_W-1:0] dv_rem_next [DIV_N];
    logic [INFL_W-1:0]   dv_dq_next  [DIV_N];

    always_comb begin
        num = sq_root_reg[ROOT_W] - ROOT_W'({cfg.full_radius, 8'b0});
    end

    always_comb begin
        logic [RADIUS_W:0] sh;
        for (int k = 0; k < DIV_N; k++) begin
            sh = {dv_rem_reg[k], dv_dq_reg[k][INFL_W-1]};
            if (sh >= {1'b0, cfg.band_width}) begin
                dv_rem_next[k] = RADIUS_W'(sh - {1'b0, cfg.band_width});
                dv_dq_next[k]  = {dv_dq_reg[k][INFL_W-2:0], 1'b1};
            end else begin
                dv_rem_next[k] = sh[RADIUS_W-1:0];
                dv_dq_next[k]  = {dv_dq_reg[k][INFL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_N; k++) begin
                dv_v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dv_v_reg[0] <= sq_v_reg[ROOT_W];
            for (int k = 0; k < DIV_N; k++) begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end
        if (en) begin
            // Dividend is num shifted left by eight; its upper bits seed the remainder.
            dv_rem_reg[0]  <= num[ROOT_W-1 -: RADIUS_W];
            dv_dq_reg[0]   <= {num[ROOT_W-RADIUS_W-1:0], 8'b0};
            dv_cls_reg[0]  <= sq_cls_reg[ROOT_W];
            dv_side_reg[0] <= sq_side_reg[ROOT_W];
            for (int k = 0; k < DIV_N; k++) begin
                dv_rem_reg[k+1]  <= dv_rem_next[k];
                dv_dq_reg[k+1]   <= dv_dq_next[k];
                dv_cls_reg[k+1]  <= dv_cls_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // Final influence selection.
    logic              out_v_reg;
    logic [INFL_W-1:0] infl_reg, infl_next;
    logic [SIDE_W-1:0] side_out_reg;

    always_comb begin
        if (dv_cls_reg[DIV_N].in_core) begin
            infl_next = INFL_ONE;
        end else if (dv_cls_reg[DIV_N].in_band) begin
            infl_next = INFL_ONE - dv_dq_reg[DIV_N];
        end else begin
            infl_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= dv_v_reg[DIV_N];
        end
        if (en) begin
            infl_reg     <= infl_next;
            side_out_reg <= dv_side_reg[DIV_N];
        end
    end

    assign out_valid = out_v_reg;
    assign infl      = infl_reg;
    assign out_side  = side_out_reg;

endmodule

[rtl/bfhb_blend.sv]
// ----------------------------------------------------------------------------
// bfhb_blend
// Forms the brush factor, adds it to the height to raise or blends the height
// toward the mode's goal in split partials, and saturates to the height range.
// ----------------------------------------------------------------------------
module bfhb_blend import bfhb_pkg::*; #(
    parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic signed [TARGET_W-1:0]     target,
    input  logic                           in_valid,
    input  logic [INFL_W-1:0]              infl,
    input  logic [KIND_W-1:0]              kind,
    input  logic signed [STRENGTH_W-1:0]   force_q,
    input  logic signed [HEIGHT_WIDTH-1:0] base,
    input  logic signed [HEIGHT_WIDTH-1:0] init,
    input  logic signed [HEIGHT_WIDTH-1:0] mean,
    output logic                           out_valid,
    output logic signed [HEIGHT_WIDTH-1:0] new_height,
    output logic [INFL_W-1:0]              falloff,
    output logic                           saturated
);

    localparam int DW    = ((HEIGHT_WIDTH > TARGET_W) ? HEIGHT_WIDTH : TARGET_W) + 1;
    localparam int FAC_W = INFL_W + 1 + STRENGTH_W;
    localparam int LO_W  = 24;
    localparam int HI_W  = DW - LO_W;
    localparam int PHI_W = HI_W + FAC_W;
    localparam int PLO_W = LO_W + 1 + FAC_W;
    localparam int RSE_W = FAC_W - 8;
    localparam int RW    = DW + 12;

    localparam logic signed [FAC_W-1:0] FAC_ONE = FAC_W'(1 << LO_W);
    localparam logic signed [RW-1:0]    HMAX    = RW'({1'b0, {(HEIGHT_WIDTH-1){1'b1}}});
    localparam logic signed [RW-1:0]    HMIN    = ~HMAX;

    // Stage 1: factor and difference to the goal height.
    logic                           v1_reg;
    logic [KIND_W-1:0]              kind1_reg;
    logic signed [HEIGHT_WIDTH-1:0] base1_reg;
    logic signed [FAC_W-1:0]        fac1_reg, fac_next;
    logic signed [DW-1:0]           diff1_reg, diff_next;
    logic [INFL_W-1:0]              infl1_reg;

    logic signed [INFL_W:0] infl_s;
    logic signed [DW-1:0]   ideal;

    always_comb begin
        infl_s   = {1'b0, infl};
        fac_next = infl_s * force_q;
        case (kind_t'(kind))
            KIND_SMOOTH:  ideal = DW'(mean);
            KIND_RESET:   ideal = DW'(init);
            KIND_FLATTEN: ideal = DW'(target);
            default:      ideal = DW'(base);
        endcase
        diff_next = ideal - DW'(base);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            kind1_reg <= kind;
            base1_reg <= base;
            fac1_reg  <= fac_next;
            diff1_reg <= diff_next;
            infl1_reg <= infl;
        end
    end

    // Stage 2: partial products of the difference halves with the factor.
    logic                           v2_reg;
    logic [KIND_W-1:0]              kind2_reg;
    logic signed [HEIGHT_WIDTH-1:0] base2_reg;
    logic signed [PHI_W-1:0]        phi2_reg;
    logic signed [PLO_W-1:0]        plo2_reg;
    logic signed [RSE_W-1:0]        raise2_reg;
    logic [INFL_W-1:0]              infl2_reg;

    logic signed [FAC_W-1:0] fac_eff;
    logic signed [HI_W-1:0]  d_hi;
    logic signed [LO_W:0]    d_lo;
    logic signed [PHI_W-1:0] phi_next;
    logic signed [PLO_W-1:0] plo_next;

    always_comb begin
        // Smoothing never pulls beyond the mean.
        if ((kind_t'(kind1_reg) == KIND_SMOOTH) && (fac1_reg > FAC_ONE)) begin
            fac_eff = '0;
        end else begin
            fac_eff = fac1_reg;
        end
        d_hi     = $signed(diff1_reg[DW-1:LO_W]);
        d_lo     = $signed({1'b0, diff1_reg[LO_W-1:0]});
        phi_next = d_hi * fac_eff;
        plo_next = d_lo * fac_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            kind2_reg  <= kind1_reg;
            base2_reg  <= base1_reg;
            phi2_reg   <= phi_next;
            plo2_reg   <= plo_next;
            raise2_reg <= $signed(fac1_reg[FAC_W-1:8]);
            infl2_reg  <= infl1_reg;
        end
    end

    // Stage 3: unclamped new height.
    logic                    v3_reg;
    logic                    pass3_reg;
    logic signed [RW-1:0]    res3_reg, res_next;
    logic [INFL_W-1:0]       infl3_reg;
    logic signed [PLO_W-LO_W-1:0] lo_term;
    logic                    pass_next;

    always_comb begin
        lo_term   = $signed(plo2_reg[PLO_W-1:LO_W]);
        pass_next = 1'b0;
        case (kind_t'(kind2_reg))
            KIND_RAISE: res_next = RW'(base2_reg) + RW'(raise2_reg);
            KIND_SMOOTH, KIND_RESET, KIND_FLATTEN:
                res_next = RW'(base2_reg) + RW'(phi2_reg) + RW'(lo_term);
            default: begin
                res_next  = RW'(base2_reg);
                pass_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            res3_reg  <= res_next;
            pass3_reg <= pass_next;
            infl3_reg <= infl2_reg;
        end
    end

    // Stage 4: saturation into the output register.
    logic                           v4_reg;
    logic signed [HEIGHT_WIDTH-1:0] height4_reg, height_next;
    logic [INFL_W-1:0]              infl4_reg;
    logic                           sat4_reg, sat_next;

    always_comb begin
        if (res3_reg > HMAX) begin
            height_next = HMAX[HEIGHT_WIDTH-1:0];
            sat_next    = 1'b1;
        end else if (res3_reg < HMIN) begin
            height_next = HMIN[HEIGHT_WIDTH-1:0];
            sat_next    = 1'b1;
        end else begin
            height_next = res3_reg[HEIGHT_WIDTH-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            height4_reg <= height_next;
            infl4_reg   <= infl3_reg;
            sat4_reg    <= sat_next && !pass3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign new_height = height4_reg;
    assign falloff    = infl4_reg;
    assign saturated  = sat4_reg;

endmodule
